// File: sv/rb2d_pkg.sv
// ----------------------------------------------------------------------------
// rb2d_pkg: shared types and constants of the 2D rigid body integrator.
// Word width, fraction width, command codes and register indexes.
// ----------------------------------------------------------------------------
package rb2d_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_BITS = 2 * WORD_BITS;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;

    localparam logic [2:0] OP_FORCE      = 3'd0;
    localparam logic [2:0] OP_FORCE_AT   = 3'd1;
    localparam logic [2:0] OP_IMPULSE    = 3'd2;
    localparam logic [2:0] OP_IMPULSE_AT = 3'd3;
    localparam logic [2:0] OP_ANG_IMP    = 3'd4;
    localparam logic [2:0] OP_TORQUE     = 3'd5;
    localparam logic [2:0] OP_STEP       = 3'd6;

    localparam logic [2:0] REG_MASS      = 3'd0;
    localparam logic [2:0] REG_INV_MASS  = 3'd1;
    localparam logic [2:0] REG_INV_INER  = 3'd2;
    localparam logic [2:0] REG_GRAV_X    = 3'd3;
    localparam logic [2:0] REG_GRAV_Y    = 3'd4;
    localparam logic [2:0] REG_LIN_DRAG  = 3'd5;
    localparam logic [2:0] REG_ANG_DRAG  = 3'd6;
    localparam logic [2:0] REG_TIME_STEP = 3'd7;

    localparam longint ONE_Q      = longint'(1) << FRAC_BITS;
    localparam longint TWO_PI_Q   = (longint'(628) << FRAC_BITS) / 100;
    localparam longint MIN_SPIN_Q = (longint'(1) << FRAC_BITS) / 100;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    // Saturate a wide signed value to the word range.
    function automatic word_t sat_prod(input prod_t v);
        prod_t hi;
        prod_t lo;
        hi = PROD_BITS'(WORD_MAX);
        lo = PROD_BITS'(WORD_MIN);
        if (v > hi) begin
            return WORD_MAX;
        end
        if (v < lo) begin
            return WORD_MIN;
        end
        return v[WORD_BITS-1:0];
    endfunction

    // Saturating add of two words.
    function automatic word_t sat_add(input word_t a, input word_t b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1]) begin
            return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        end
        return s[WORD_BITS-1:0];
    endfunction

    // Saturating subtract of two words.
    function automatic word_t sat_sub(input word_t a, input word_t b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1]) begin
            return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        end
        return s[WORD_BITS-1:0];
    endfunction

    // Shift a product right, truncating toward zero.
    function automatic prod_t shr_trunc(input prod_t p, input int sh);
        prod_t mag;
        mag = p[PROD_BITS-1] ? -p : p;
        mag = mag >>> sh;
        return p[PROD_BITS-1] ? -mag : mag;
    endfunction

endpackage

// File: sv/rigid_body_2d_integrator.sv
// ----------------------------------------------------------------------------
// rigid_body_2d_integrator
// Fixed-point 2D rigid body with accumulators and a leapfrog step command.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the s_ channel as valid/ready requests. Force, torque
// and impulse commands update the accumulators or momenta and give no result.
// A step command runs a sequence over one shared 32x32 multiplier and gives
// one result request on the m_ channel with the new position, angle and
// momenta.
// Sequence: a non-step command passes through the command step, after the
// two cross product steps when it has a point offset. A step runs the
// sequencer steps from the drag steps to the snap step, each forming one
// product on the multiplier, then loads the result register and waits in
// the output step until the receiver takes the result.
// The block takes no request while it works or while a result waits; the
// result register holds its value while the receiver stalls.
// Reset (aresetn low, synchronous) clears the body state and accumulators,
// returns to idle and sets the registers to their reset values: mass,
// inverse mass and inverse inertia 1.0 and the time step 1092.
// Configuration writes through cfg_we/cfg_index/cfg_data take effect at once.
// ----------------------------------------------------------------------------
module rigid_body_2d_integrator import rb2d_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [WORD_BITS-1:0] cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_opcode,
    input  logic signed [WORD_BITS-1:0] s_vec_x,
    input  logic signed [WORD_BITS-1:0] s_vec_y,
    input  logic signed [WORD_BITS-1:0] s_offset_x,
    input  logic signed [WORD_BITS-1:0] s_offset_y,
    input  logic signed [WORD_BITS-1:0] s_scalar_amount,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [WORD_BITS-1:0] m_out_pos_x,
    output logic signed [WORD_BITS-1:0] m_out_pos_y,
    output logic signed [WORD_BITS-1:0] m_out_angle,
    output logic signed [WORD_BITS-1:0] m_out_mom_x,
    output logic signed [WORD_BITS-1:0] m_out_mom_y,
    output logic signed [WORD_BITS-1:0] m_out_ang_mom
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_CMD, ST_CR1, ST_CR2,
        ST_DRAG_X, ST_DRAG_Y, ST_DRAG_W, ST_GRAV_X, ST_GRAV_Y,
        ST_KICK_X, ST_KICK_Y, ST_VEL_X, ST_POS_X, ST_VEL_Y, ST_POS_Y,
        ST_KICK_W, ST_LIMIT, ST_ROT, ST_SNAP, ST_OUT
    } state_t;

    state_t state_reg;

    // Configuration registers.
    word_t mass_reg, inv_mass_reg, inv_iner_reg, grav_x_reg, grav_y_reg;
    word_t lin_drag_reg, ang_drag_reg, time_step_reg;

    // Body state.
    word_t mom_x_reg, mom_y_reg, spin_reg;
    word_t fsum_x_reg, fsum_y_reg, tsum_reg;
    word_t pos_x_reg, pos_y_reg, rot_reg;

    // Latched command and step temporaries.
    logic [2:0] op_reg;
    word_t vx_reg, vy_reg, ox_reg, oy_reg, amt_reg;
    word_t hx_reg, hy_reg, k_reg, tmp_reg, cross_reg;

    // Shared multiplier operands and result.
    word_t mul_a, mul_b;
    prod_t prod;
    word_t fm_res;
    word_t hk_res;
    word_t limit_neg;
    word_t spin_new;

    assign prod   = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    assign fm_res = sat_prod(shr_trunc(prod, FRAC_BITS));
    assign hk_res = sat_prod(shr_trunc(prod, FRAC_BITS + 1));
    assign limit_neg = -fm_res;

    // Operand selection for the multiplier by sequencer step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_CR1:    begin mul_a = ox_reg;       mul_b = vy_reg;        end
            ST_CR2:    begin mul_a = oy_reg;       mul_b = vx_reg;        end
            ST_DRAG_X: begin mul_a = lin_drag_reg; mul_b = mom_x_reg;     end
            ST_DRAG_Y: begin mul_a = lin_drag_reg; mul_b = mom_y_reg;     end
            ST_DRAG_W: begin mul_a = ang_drag_reg; mul_b = spin_reg;      end
            ST_GRAV_X: begin mul_a = grav_x_reg;   mul_b = mass_reg;      end
            ST_GRAV_Y: begin mul_a = grav_y_reg;   mul_b = mass_reg;      end
            ST_KICK_X: begin mul_a = fsum_x_reg;   mul_b = time_step_reg; end
            ST_KICK_Y: begin mul_a = fsum_y_reg;   mul_b = time_step_reg; end
            ST_VEL_X:  begin mul_a = mom_x_reg;    mul_b = inv_mass_reg;  end
            ST_POS_X:  begin mul_a = tmp_reg;      mul_b = time_step_reg; end
            ST_VEL_Y:  begin mul_a = mom_y_reg;    mul_b = inv_mass_reg;  end
            ST_POS_Y:  begin mul_a = tmp_reg;      mul_b = time_step_reg; end
            ST_KICK_W: begin mul_a = tsum_reg;     mul_b = time_step_reg; end
            ST_LIMIT:  begin mul_a = word_t'(TWO_PI_Q); mul_b = mass_reg; end
            ST_ROT:    begin mul_a = spin_reg;     mul_b = inv_iner_reg;  end
            ST_SNAP:   begin mul_a = spin_reg;     mul_b = inv_iner_reg;  end
            default:   begin mul_a = '0;           mul_b = '0;            end
        endcase
    end

    assign spin_new = sat_add(spin_reg, k_reg);

    assign s_ready = (state_reg == ST_IDLE);

    // Configuration port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mass_reg      <= word_t'(ONE_Q);
            inv_mass_reg  <= word_t'(ONE_Q);
            inv_iner_reg  <= word_t'(ONE_Q);
            grav_x_reg    <= '0;
            grav_y_reg    <= '0;
            lin_drag_reg  <= '0;
            ang_drag_reg  <= '0;
            time_step_reg <= word_t'(1092);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MASS:      mass_reg      <= {1'b0, cfg_data[WORD_BITS-2:0]};
                REG_INV_MASS:  inv_mass_reg  <= {1'b0, cfg_data[WORD_BITS-2:0]};
                REG_INV_INER:  inv_iner_reg  <= {1'b0, cfg_data[WORD_BITS-2:0]};
                REG_GRAV_X:    grav_x_reg    <= cfg_data;
                REG_GRAV_Y:    grav_y_reg    <= cfg_data;
                REG_LIN_DRAG:  lin_drag_reg  <= {1'b0, cfg_data[WORD_BITS-2:0]};
                REG_ANG_DRAG:  ang_drag_reg  <= {1'b0, cfg_data[WORD_BITS-2:0]};
                REG_TIME_STEP: time_step_reg <= {1'b0, cfg_data[WORD_BITS-2:0]};
                default: ;
            endcase
        end
    end

    // Sequencer, state updates and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            m_valid    <= 1'b0;
            mom_x_reg  <= '0;
            mom_y_reg  <= '0;
            spin_reg   <= '0;
            fsum_x_reg <= '0;
            fsum_y_reg <= '0;
            tsum_reg   <= '0;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            rot_reg    <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg  <= s_opcode;
                        vx_reg  <= s_vec_x;
                        vy_reg  <= s_vec_y;
                        ox_reg  <= s_offset_x;
                        oy_reg  <= s_offset_y;
                        amt_reg <= s_scalar_amount;
                        if (s_opcode == OP_STEP) begin
                            state_reg <= ST_DRAG_X;
                        end else if (s_opcode == OP_FORCE_AT ||
                                     s_opcode == OP_IMPULSE_AT) begin
                            state_reg <= ST_CR1;
                        end else begin
                            state_reg <= ST_CMD;
                        end
                    end
                end
                ST_CR1: begin
                    tmp_reg   <= fm_res;
                    state_reg <= ST_CR2;
                end
                ST_CR2: begin
                    cross_reg <= sat_sub(tmp_reg, fm_res);
                    state_reg <= ST_CMD;
                end
                ST_CMD: begin
                    unique case (op_reg)
                        OP_FORCE, OP_FORCE_AT: begin
                            fsum_x_reg <= sat_add(fsum_x_reg, vx_reg);
                            fsum_y_reg <= sat_add(fsum_y_reg, vy_reg);
                            if (op_reg == OP_FORCE_AT) begin
                                tsum_reg <= sat_add(tsum_reg, cross_reg);
                            end
                        end
                        OP_IMPULSE, OP_IMPULSE_AT: begin
                            mom_x_reg <= sat_add(mom_x_reg, vx_reg);
                            mom_y_reg <= sat_add(mom_y_reg, vy_reg);
                            if (op_reg == OP_IMPULSE_AT) begin
                                spin_reg <= sat_add(spin_reg, cross_reg);
                            end
                        end
                        OP_ANG_IMP: spin_reg <= sat_add(spin_reg, amt_reg);
                        OP_TORQUE:  tsum_reg <= sat_add(tsum_reg, amt_reg);
                        default: ;
                    endcase
                    state_reg <= ST_IDLE;
                end
                ST_DRAG_X: begin
                    fsum_x_reg <= sat_sub(fsum_x_reg, fm_res);
                    state_reg  <= ST_DRAG_Y;
                end
                ST_DRAG_Y: begin
                    fsum_y_reg <= sat_sub(fsum_y_reg, fm_res);
                    state_reg  <= ST_DRAG_W;
                end
                ST_DRAG_W: begin
                    tsum_reg  <= sat_sub(tsum_reg, fm_res);
                    state_reg <= ST_GRAV_X;
                end
                ST_GRAV_X: begin
                    fsum_x_reg <= sat_add(fsum_x_reg, fm_res);
                    state_reg  <= ST_GRAV_Y;
                end
                ST_GRAV_Y: begin
                    fsum_y_reg <= sat_add(fsum_y_reg, fm_res);
                    state_reg  <= ST_KICK_X;
                end
                ST_KICK_X: begin
                    hx_reg    <= hk_res;
                    mom_x_reg <= sat_add(mom_x_reg, hk_res);
                    state_reg <= ST_KICK_Y;
                end
                ST_KICK_Y: begin
                    hy_reg    <= hk_res;
                    mom_y_reg <= sat_add(mom_y_reg, hk_res);
                    state_reg <= ST_VEL_X;
                end
                ST_VEL_X: begin
                    tmp_reg   <= fm_res;
                    state_reg <= ST_POS_X;
                end
                ST_POS_X: begin
                    pos_x_reg  <= sat_add(pos_x_reg, fm_res);
                    mom_x_reg  <= sat_add(mom_x_reg, hx_reg);
                    fsum_x_reg <= '0;
                    state_reg  <= ST_VEL_Y;
                end
                ST_VEL_Y: begin
                    tmp_reg   <= fm_res;
                    state_reg <= ST_POS_Y;
                end
                ST_POS_Y: begin
                    pos_y_reg  <= sat_add(pos_y_reg, fm_res);
                    mom_y_reg  <= sat_add(mom_y_reg, hy_reg);
                    fsum_y_reg <= '0;
                    state_reg  <= ST_KICK_W;
                end
                ST_KICK_W: begin
                    k_reg     <= hk_res;
                    state_reg <= ST_LIMIT;
                end
                ST_LIMIT: begin
                    // Clamp the kicked spin to the mass-scaled limit.
                    if (spin_new > fm_res) begin
                        spin_reg <= fm_res;
                    end else if (spin_new < limit_neg) begin
                        spin_reg <= limit_neg;
                    end else begin
                        spin_reg <= spin_new;
                    end
                    state_reg <= ST_ROT;
                end
                ST_ROT: begin
                    rot_reg   <= sat_add(rot_reg, fm_res);
                    spin_reg  <= spin_new;
                    tsum_reg  <= '0;
                    state_reg <= ST_SNAP;
                end
                ST_SNAP: begin
                    // Small angular velocity snaps to rest.
                    if (fm_res < word_t'(MIN_SPIN_Q) &&
                        fm_res > -word_t'(MIN_SPIN_Q)) begin
                        spin_reg <= '0;
                        m_out_ang_mom <= '0;
                    end else begin
                        m_out_ang_mom <= spin_reg;
                    end
                    m_out_pos_x <= pos_x_reg;
                    m_out_pos_y <= pos_y_reg;
                    m_out_angle <= rot_reg;
                    m_out_mom_x <= mom_x_reg;
                    m_out_mom_y <= mom_y_reg;
                    m_valid     <= 1'b1;
                    state_reg   <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid   <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // A result is shown only while the sequencer waits in its output step.
    a_valid_in_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> state_reg == ST_OUT)
        else $error("result valid outside output step");

    // No new request is taken while a result waits.
    a_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("ready while result pending");

    // A step request leads to the drag step next.
    a_step_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_opcode == OP_STEP) |=> state_reg == ST_DRAG_X)
        else $error("step did not start sequence");
`endif

endmodule
